// ----- rtl/core/frx_pkg.sv -----
`timescale 1ns / 1ps
// frx_pkg: shared types and constants of the framed packet receiver.
// No dependencies; imported by every module in rtl/core but frx_ram.
package frx_pkg;

  // Largest data field a frame may carry; payload store depth.
  localparam int MAX_DATA = 32;
  localparam int ADDR_W   = $clog2(MAX_DATA);
  localparam int LEN_W    = $clog2(MAX_DATA + 1);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_DATA);

  // Configuration register indexes
  localparam logic [1:0] CFG_FIRST_HEADER  = 2'd0;
  localparam logic [1:0] CFG_SECOND_HEADER = 2'd1;
  localparam logic [1:0] CFG_TRAILER       = 2'd2;

  localparam logic [7:0] FIRST_HEADER_RST  = 8'hAA;
  localparam logic [7:0] SECOND_HEADER_RST = 8'h55;
  localparam logic [7:0] TRAILER_RST       = 8'h0D;

  typedef enum logic [2:0] {
    PH_HEAD1,
    PH_HEAD2,
    PH_CMDH,
    PH_CMDL,
    PH_LEN,
    PH_DATA,
    PH_SUM,
    PH_TAIL
  } phase_t;

  typedef enum logic [1:0] {
    DR_IDLE,
    DR_WAIT,
    DR_READ,
    DR_LOAD
  } drain_state_t;

  // Handoff from parser to drain sequencer for a frame that passed all checks
  typedef struct packed {
    logic             start;
    logic [15:0]      command;
    logic [LEN_W-1:0] length;
  } frx_launch_t;

endpackage

// ----- rtl/core/framed_packet_receiver_sum8.sv -----
`timescale 1ns / 1ps
// framed_packet_receiver_sum8: top level, parser + payload RAM + drain.
// Depends on frx_pkg, frx_parser, frx_ram, frx_drain.
//
// Takes one received byte per accepted word and parses frames of the form
// head1, head2, cmd_hi, cmd_lo, length, data..., sum8, trailer. Data bytes are
// written into a 32-entry payload RAM as they arrive; a frame whose checksum
// matches and which closes with the trailer byte is read back from that RAM
// and emitted as one result per data byte (a single no-data result for a
// zero-length frame). Every byte outside a drain is accepted without a
// stall. After a matching trailer the input stalls while the frame drains:
// each result passes through three steps (wait for the output register, RAM
// read, load), and the input stays stalled until the last result is loaded,
// including any time the output side stalls. The last result may still wait
// in the output register while new bytes are accepted.
module framed_packet_receiver_sum8 (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [7:0]                 cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 rx_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [15:0]                frame_command,
  output logic [frx_pkg::LEN_W-1:0]  frame_length,
  output logic [7:0]                 payload_byte,
  output logic [frx_pkg::ADDR_W-1:0] payload_index,
  output logic                       has_payload,
  output logic                       last
);
  import frx_pkg::*;

  logic              accept;
  logic              busy;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_rdata;
  frx_launch_t       launch;

  // RAM writes and reads never overlap: input is stalled during a drain
  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;

  frx_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .launch    (launch)
  );

  frx_ram #(
    .DEPTH (MAX_DATA),
    .WIDTH (8)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  frx_drain u_drain (
    .clk           (clk),
    .rst           (rst),
    .launch        (launch),
    .busy          (busy),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_command (frame_command),
    .frame_length  (frame_length),
    .payload_byte  (payload_byte),
    .payload_index (payload_index),
    .has_payload   (has_payload),
    .last          (last)
  );

endmodule

// ----- rtl/core/frx_ram.sv -----
`timescale 1ns / 1ps
// frx_ram: simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module frx_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/frx_parser.sv -----
`timescale 1ns / 1ps
// frx_parser: byte-level frame state machine, checksum, config registers.
// Depends on frx_pkg; writes data bytes into the payload RAM.
module frx_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [7:0]                cfg_data,
  input  logic                      accept,
  input  logic [7:0]                rx_byte,
  output logic                      mem_we,
  output logic [frx_pkg::ADDR_W-1:0] mem_waddr,
  output logic [7:0]                mem_wdata,
  output frx_pkg::frx_launch_t      launch
);
  import frx_pkg::*;

  logic [7:0]       first_header;
  logic [7:0]       second_header;
  logic [7:0]       trailer;
  phase_t           phase;
  phase_t           phase_next;
  logic [15:0]      command_word;
  logic [LEN_W-1:0] expected_length;
  logic [LEN_W-1:0] byte_position;
  logic [LEN_W-1:0] position_next;
  logic [7:0]       running_sum;
  logic             store_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_header  <= FIRST_HEADER_RST;
      second_header <= SECOND_HEADER_RST;
      trailer       <= TRAILER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_HEADER:  first_header  <= cfg_data;
        CFG_SECOND_HEADER: second_header <= cfg_data;
        CFG_TRAILER:       trailer       <= cfg_data;
        default: ;
      endcase
    end
  end

  assign store_ok      = byte_position < MAX_LEN;
  assign position_next = store_ok ? byte_position + LEN_W'(1) : byte_position;

  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        PH_HEAD1: if (rx_byte == first_header) phase_next = PH_HEAD2;
        PH_HEAD2: begin
          if (rx_byte == second_header) phase_next = PH_CMDH;
          else if (rx_byte == first_header) phase_next = PH_HEAD2;
          else phase_next = PH_HEAD1;
        end
        PH_CMDH: phase_next = PH_CMDL;
        PH_CMDL: phase_next = PH_LEN;
        PH_LEN: begin
          if (rx_byte > 8'(MAX_DATA)) phase_next = PH_HEAD1;
          else if (rx_byte == 8'd0) phase_next = PH_SUM;
          else phase_next = PH_DATA;
        end
        PH_DATA: if (position_next >= expected_length) phase_next = PH_SUM;
        PH_SUM:  phase_next = (rx_byte == running_sum) ? PH_TAIL : PH_HEAD1;
        PH_TAIL: phase_next = PH_HEAD1;
      endcase
    end
  end

  always_comb begin
    mem_we         = accept && (phase == PH_DATA) && store_ok;
    mem_waddr      = byte_position[ADDR_W-1:0];
    mem_wdata      = rx_byte;
    launch.start   = accept && (phase == PH_TAIL) && (rx_byte == trailer);
    launch.command = command_word;
    launch.length  = expected_length;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEAD1;
      command_word    <= '0;
      expected_length <= '0;
      byte_position   <= '0;
      running_sum     <= '0;
    end else begin
      phase <= phase_next;
      if (accept) begin
        case (phase)
          PH_CMDH: begin
            command_word <= {rx_byte, 8'd0};
            running_sum  <= rx_byte;
          end
          PH_CMDL: begin
            command_word <= {command_word[15:8], rx_byte};
            running_sum  <= running_sum + rx_byte;
          end
          PH_LEN: begin
            if (rx_byte <= 8'(MAX_DATA)) begin
              expected_length <= rx_byte[LEN_W-1:0];
              running_sum     <= running_sum + rx_byte;
              byte_position   <= '0;
            end
          end
          PH_DATA: begin
            byte_position <= position_next;
            running_sum   <= running_sum + rx_byte;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- rtl/core/frx_drain.sv -----
`timescale 1ns / 1ps
// frx_drain: reads a checked frame out of the payload RAM into the output
// register: one result per data byte, one if empty. Depends on frx_pkg.
module frx_drain (
  input  logic                       clk,
  input  logic                       rst,
  input  frx_pkg::frx_launch_t       launch,
  output logic                       busy,
  output logic [frx_pkg::ADDR_W-1:0] mem_raddr,
  input  logic [7:0]                 mem_rdata,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [15:0]                frame_command,
  output logic [frx_pkg::LEN_W-1:0]  frame_length,
  output logic [7:0]                 payload_byte,
  output logic [frx_pkg::ADDR_W-1:0] payload_index,
  output logic                       has_payload,
  output logic                       last
);
  import frx_pkg::*;

  drain_state_t     state;
  drain_state_t     state_next;
  logic [15:0]      cmd;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] cnt;
  logic             out_take;
  logic             load;
  logic             load_last;
  logic             load_has;

  assign out_take  = out_valid && !out_stall;
  assign load_has  = len != '0;
  assign load_last = !load_has || (cnt + LEN_W'(1) == len);

  always_comb begin
    state_next = state;
    unique case (state)
      DR_IDLE: if (launch.start) state_next = DR_WAIT;
      DR_WAIT: if (!out_valid || out_take) state_next = DR_READ;
      DR_READ: state_next = DR_LOAD;
      DR_LOAD: state_next = load_last ? DR_IDLE : DR_WAIT;
    endcase
  end

  always_comb begin
    busy      = state != DR_IDLE;
    load      = state == DR_LOAD;
    mem_raddr = cnt[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= DR_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
        cnt       <= cnt + LEN_W'(1);
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
      if (state == DR_IDLE && launch.start) begin
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == DR_IDLE && launch.start) begin
      cmd <= launch.command;
      len <= launch.length;
    end
    if (load) begin
      frame_command <= cmd;
      frame_length  <= len;
      payload_byte  <= load_has ? mem_rdata : 8'd0;
      payload_index <= load_has ? cnt[ADDR_W-1:0] : '0;
      has_payload   <= load_has;
      last          <= load_last;
    end
  end

`ifndef NO_ASSERTIONS
  // input is held off while draining, so no new frame can arrive mid-drain
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    launch.start |-> state == DR_IDLE)
    else $error("frame launched while drain busy");

  // output register must be empty when read data lands
  a_load_empty: assert property (@(posedge clk) disable iff (rst)
    state == DR_LOAD |-> !out_valid)
    else $error("output register overwritten");

  a_read_load: assert property (@(posedge clk) disable iff (rst)
    state == DR_READ |=> state == DR_LOAD)
    else $error("read not followed by load");

  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == DR_LOAD)
    else $error("result shown without a RAM load");
`endif

endmodule

// ----- sim/frx_checker.sv -----
`timescale 1ns / 1ps
// frx_checker: watches the config port and both word channels of the frame receiver,
// predicts the frame results and compares each accepted output word against them.
// Depends on frx_pkg for widths, phases and register indexes.
module frx_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [7:0]                 cfg_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [7:0]                 rx_byte,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [15:0]                frame_command,
  input  logic [frx_pkg::LEN_W-1:0]  frame_length,
  input  logic [7:0]                 payload_byte,
  input  logic [frx_pkg::ADDR_W-1:0] payload_index,
  input  logic                       has_payload,
  input  logic                       last,
  output int                         fail_count,
  output int                         results_due
);

  typedef struct packed {
    logic [15:0]                command;
    logic [frx_pkg::LEN_W-1:0]  length;
    logic [7:0]                 data;
    logic [frx_pkg::ADDR_W-1:0] index;
    logic                       has_data;
    logic                       last;
  } frame_result_t;

  frame_result_t results_q[$];

  logic [7:0]                head1;
  logic [7:0]                head2;
  logic [7:0]                trailer;
  frx_pkg::phase_t           parse_ph;
  logic [15:0]               cmd_word;
  logic [frx_pkg::LEN_W-1:0] exp_len;
  logic [frx_pkg::LEN_W-1:0] pos;
  logic [7:0]                sum8;
  logic [7:0]                payload_copy [frx_pkg::MAX_DATA];

  function automatic void parse_byte(input logic [7:0] b);
    frame_result_t r;
    logic [frx_pkg::LEN_W-1:0] k;
    case (parse_ph)
      frx_pkg::PH_HEAD1: begin
        if (b == head1) parse_ph = frx_pkg::PH_HEAD2;
      end
      frx_pkg::PH_HEAD2: begin
        if (b == head2) parse_ph = frx_pkg::PH_CMDH;
        else if (b == head1) parse_ph = frx_pkg::PH_HEAD2;
        else parse_ph = frx_pkg::PH_HEAD1;
      end
      frx_pkg::PH_CMDH: begin
        cmd_word = {b, 8'h00};
        sum8     = b;
        parse_ph = frx_pkg::PH_CMDL;
      end
      frx_pkg::PH_CMDL: begin
        cmd_word[7:0] = b;
        sum8          = sum8 + b;
        parse_ph      = frx_pkg::PH_LEN;
      end
      frx_pkg::PH_LEN: begin
        if (b > frx_pkg::MAX_DATA) begin
          parse_ph = frx_pkg::PH_HEAD1;
        end else begin
          exp_len  = b[frx_pkg::LEN_W-1:0];
          sum8     = sum8 + b;
          pos      = '0;
          parse_ph = (b == 8'd0) ? frx_pkg::PH_SUM : frx_pkg::PH_DATA;
        end
      end
      frx_pkg::PH_DATA: begin
        if (pos < frx_pkg::MAX_LEN) begin
          payload_copy[pos[frx_pkg::ADDR_W-1:0]] = b;
          pos = pos + 1'b1;
        end
        sum8 = sum8 + b;
        if (pos >= exp_len) parse_ph = frx_pkg::PH_SUM;
      end
      frx_pkg::PH_SUM: begin
        parse_ph = (b == sum8) ? frx_pkg::PH_TAIL : frx_pkg::PH_HEAD1;
      end
      default: begin
        // any byte closes the frame; only the trailer releases it
        if (b == trailer) begin
          if (exp_len == '0) begin
            r = '{command: cmd_word, length: '0, data: '0, index: '0,
                  has_data: 1'b0, last: 1'b1};
            results_q.push_back(r);
          end else begin
            for (k = '0; k < exp_len; k++) begin
              r.command  = cmd_word;
              r.length   = exp_len;
              r.data     = payload_copy[k[frx_pkg::ADDR_W-1:0]];
              r.index    = k[frx_pkg::ADDR_W-1:0];
              r.has_data = 1'b1;
              r.last     = (k + 1 == exp_len);
              results_q.push_back(r);
            end
          end
        end
        parse_ph = frx_pkg::PH_HEAD1;
      end
    endcase
  endfunction

  task automatic take_result();
    frame_result_t want;
    if (results_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected frame result: cmd %h len %0d byte %h idx %0d has %b last %b",
                 frame_command, frame_length, payload_byte, payload_index,
                 has_payload, last);
      return;
    end
    want = results_q.pop_front();
    if (frame_command !== want.command || frame_length !== want.length ||
        payload_byte !== want.data || payload_index !== want.index ||
        has_payload !== want.has_data || last !== want.last) begin
      fail_count++;
      if (fail_count <= 10)
        $display({"frame result mismatch: want cmd %h len %0d byte %h idx %0d has %b last %b",
                  " / got cmd %h len %0d byte %h idx %0d has %b last %b"},
                 want.command, want.length, want.data, want.index, want.has_data,
                 want.last, frame_command, frame_length, payload_byte, payload_index,
                 has_payload, last);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      head1    = frx_pkg::FIRST_HEADER_RST;
      head2    = frx_pkg::SECOND_HEADER_RST;
      trailer  = frx_pkg::TRAILER_RST;
      parse_ph = frx_pkg::PH_HEAD1;
      cmd_word = '0;
      exp_len  = '0;
      pos      = '0;
      sum8     = '0;
      results_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          frx_pkg::CFG_FIRST_HEADER:  head1   = cfg_data;
          frx_pkg::CFG_SECOND_HEADER: head2   = cfg_data;
          frx_pkg::CFG_TRAILER:       trailer = cfg_data;
          default: ;
        endcase
      end
      // results leave only after their trailer is accepted, so check before parsing
      if (out_valid && !out_stall) take_result();
      if (in_valid && !in_stall) parse_byte(rx_byte);
    end
    results_due = results_q.size();
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for framed_packet_receiver_sum8.
// Depends on frx_pkg, the receiver RTL and frx_checker (sim/frx_checker.sv).
module tb_top;

  localparam logic [1:0] CFG_UNUSED  = 2'd3;
  localparam int         STALL_LIMIT = 2000;

  typedef enum {
    FRAME_GOOD,
    FRAME_BAD_SUM,
    FRAME_BAD_TAIL,
    FRAME_TOO_LONG,
    FRAME_CUT
  } frame_flaw_t;

  logic                       clk;
  logic                       rst       = 1'b1;
  logic                       cfg_we    = 1'b0;
  logic [1:0]                 cfg_index = 2'd0;
  logic [7:0]                 cfg_data  = 8'h00;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic [7:0]                 rx_byte   = 8'h00;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [15:0]                frame_command;
  logic [frx_pkg::LEN_W-1:0]  frame_length;
  logic [7:0]                 payload_byte;
  logic [frx_pkg::ADDR_W-1:0] payload_index;
  logic                       has_payload;
  logic                       last;

  int check_fails;
  int results_due;
  int bytes_sent;
  int stall_hold;
  int idle_cycles;
  bit quiet;

  logic [7:0] cur_h1 = frx_pkg::FIRST_HEADER_RST;
  logic [7:0] cur_h2 = frx_pkg::SECOND_HEADER_RST;
  logic [7:0] cur_trailer = frx_pkg::TRAILER_RST;

  framed_packet_receiver_sum8 dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_command (frame_command),
    .frame_length  (frame_length),
    .payload_byte  (payload_byte),
    .payload_index (payload_index),
    .has_payload   (has_payload),
    .last          (last)
  );

  frx_checker frame_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_command (frame_command),
    .frame_length  (frame_length),
    .payload_byte  (payload_byte),
    .payload_index (payload_index),
    .has_payload   (has_payload),
    .last          (last),
    .fail_count    (check_fails),
    .results_due   (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall  <= ($urandom_range(0, 99) < 40);
      stall_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // valid stays high after acceptance; callers lower it before any pause
  task automatic put_byte(input logic [7:0] b, input bit counted);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (counted) bytes_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (results_due == 0);
  endtask

  task automatic write_regs(input logic [7:0] h1, input logic [7:0] h2,
                            input logic [7:0] tr);
    cfg_we    <= 1'b1;
    cfg_index <= frx_pkg::CFG_FIRST_HEADER;
    cfg_data  <= h1;
    @(posedge clk);
    cfg_index <= frx_pkg::CFG_SECOND_HEADER;
    cfg_data  <= h2;
    @(posedge clk);
    cfg_index <= frx_pkg::CFG_TRAILER;
    cfg_data  <= tr;
    @(posedge clk);
    // unmapped index must not disturb head1
    cfg_index <= CFG_UNUSED;
    cfg_data  <= ~h1;
    @(posedge clk);
    cfg_we      <= 1'b0;
    cur_h1      = h1;
    cur_h2      = h2;
    cur_trailer = tr;
  endtask

  task automatic send_frame(input logic [15:0] cmd, input logic [7:0] len,
                            input frame_flaw_t flaw, input bit dup_head);
    logic [7:0] sum8;
    logic [7:0] b;
    int n_data;
    int i;
    put_byte(cur_h1, 1'b1);
    if (dup_head) put_byte(cur_h1, 1'b1);
    put_byte(cur_h2, 1'b1);
    put_byte(cmd[15:8], 1'b1);
    put_byte(cmd[7:0], 1'b1);
    put_byte(len, 1'b1);
    if (flaw == FRAME_TOO_LONG) return;
    sum8 = cmd[15:8] + cmd[7:0] + len;
    n_data = (flaw == FRAME_CUT) ? int'(len) / 2 : int'(len);
    for (i = 0; i < n_data; i++) begin
      b = 8'($urandom_range(0, 255));
      put_byte(b, 1'b1);
      sum8 = sum8 + b;
    end
    // a cut frame leaves the parser mid-data; the next frame lands in it
    if (flaw == FRAME_CUT) return;
    if (flaw == FRAME_BAD_SUM) put_byte(sum8 ^ 8'($urandom_range(1, 255)), 1'b1);
    else put_byte(sum8, 1'b1);
    if (flaw == FRAME_BAD_TAIL) put_byte(cur_trailer ^ 8'($urandom_range(1, 255)), 1'b1);
    else put_byte(cur_trailer, 1'b1);
  endtask

  task automatic send_random_frame();
    int r;
    int sel;
    int i;
    logic [7:0] len;
    frame_flaw_t flaw;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      for (i = $urandom_range(1, 6); i > 0; i--) put_byte(8'($urandom_range(0, 255)), 1'b1);
      return;
    end
    if (r < 72) flaw = FRAME_GOOD;
    else if (r < 80) flaw = FRAME_BAD_SUM;
    else if (r < 87) flaw = FRAME_BAD_TAIL;
    else if (r < 93) flaw = FRAME_TOO_LONG;
    else flaw = FRAME_CUT;
    sel = $urandom_range(0, 99);
    if (flaw == FRAME_TOO_LONG) len = 8'($urandom_range(frx_pkg::MAX_DATA + 1, 255));
    else if (sel < 75) len = 8'($urandom_range(0, 4));
    else if (sel < 95) len = 8'($urandom_range(5, 16));
    else len = 8'($urandom_range(17, frx_pkg::MAX_DATA));
    send_frame(16'($urandom_range(0, 65535)), len, flaw,
               (cur_h1 != cur_h2) && ($urandom_range(0, 99) < 15));
    if (flaw == FRAME_GOOD && $urandom_range(0, 99) < 8) drain_results();
  endtask

  // push the parser back to idle with bytes that cannot open or close a frame
  task automatic next_setting(input logic [7:0] h1, input logic [7:0] h2,
                              input logic [7:0] tr);
    logic [7:0] filler;
    do filler = 8'($urandom_range(0, 255));
    while (filler == cur_h1 || filler == cur_h2 || filler == cur_trailer);
    repeat (frx_pkg::MAX_DATA + 6) put_byte(filler, 1'b1);
    drain_results();
    repeat (8) @(posedge clk);
    write_regs(h1, h2, tr);
  endtask

  task automatic run_random(input int target);
    while (bytes_sent < target) send_random_frame();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    write_regs(frx_pkg::FIRST_HEADER_RST, frx_pkg::SECOND_HEADER_RST,
               frx_pkg::TRAILER_RST);

    // directed: zero length with repeated head1, oversize length,
    // bad checksum, wrong trailer, then a full-size frame
    send_frame(16'hFFFF, 8'd0, FRAME_GOOD, 1'b1);
    send_frame(16'h0000, 8'(frx_pkg::MAX_DATA + 1), FRAME_TOO_LONG, 1'b0);
    send_frame(16'h8001, 8'd0, FRAME_BAD_SUM, 1'b0);
    send_frame(16'h7FFE, 8'd1, FRAME_BAD_TAIL, 1'b0);
    send_frame(16'($urandom_range(0, 65535)), 8'(frx_pkg::MAX_DATA), FRAME_GOOD, 1'b0);
    run_random(80);

    next_setting(8'h00, 8'hFF, 8'h00);
    quiet <= 1'b1;
    run_random(135);

    next_setting(8'hFF, 8'h00, 8'hFF);
    quiet <= 1'b0;
    run_random(190);

    next_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
    run_random(230);

    drain_results();
    repeat (30) @(posedge clk);
    if (check_fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
